// ----- sv/lsva_pkg.sv -----
// Shared types and constants for the shadow vertex alpha pipeline.
// No dependencies.
package lsva_pkg;

    localparam int NORM_W   = 16;
    localparam int ENERGY_W = 9;
    localparam int ALPHA_W  = 9;
    localparam int FADE_W   = 17;
    localparam int ATT_W    = 17;
    localparam int QUOT_W   = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_DIR    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VEC_X  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VEC_Y  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VEC_Z  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REACH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ENERGY = 3'd5;

    // reciprocals: floor(n/9) for n < 2^20 and floor(n/81) for n < 2^23
    localparam logic [20:0] RECIP_9   = 21'd1864136;
    localparam int          RECIP_9_SH = 24;
    localparam logic [23:0] RECIP_81  = 24'd13256072;
    localparam int          RECIP_81_SH = 30;

    localparam logic [ATT_W-1:0] ATT_FULL = 17'h10000;
    localparam logic [9:0]       ALPHA_SCALE = 10'd765;

    typedef struct packed {
        logic [FADE_W-1:0] f1;
        logic [FADE_W-1:0] f2;
        logic              full;
        logic              use_div;
    } t_side;

endpackage

// ----- sv/lsva_geom.sv -----
// Front end: differences, squares, dot product, reach test and fades.
// Depends on lsva_pkg.
module lsva_geom #(
    parameter int COORD_WIDTH = 20,
    parameter int FRAC_BITS   = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic signed [COORD_WIDTH-1:0]       i_vert_x,
    input  logic signed [COORD_WIDTH-1:0]       i_vert_y,
    input  logic signed [COORD_WIDTH-1:0]       i_vert_z,
    input  logic signed [lsva_pkg::NORM_W-1:0]  i_norm_x,
    input  logic signed [lsva_pkg::NORM_W-1:0]  i_norm_y,
    input  logic signed [lsva_pkg::NORM_W-1:0]  i_norm_z,
    input  logic signed [COORD_WIDTH-1:0]       i_cam_x,
    input  logic signed [COORD_WIDTH-1:0]       i_cam_y,
    input  logic signed [COORD_WIDTH-1:0]       i_cam_z,
    input  logic signed [COORD_WIDTH-1:0]       i_obj_x,
    input  logic signed [COORD_WIDTH-1:0]       i_obj_y,
    input  logic signed [COORD_WIDTH-1:0]       i_obj_z,
    input  logic                                i_dir,
    input  logic signed [COORD_WIDTH-1:0]       i_lv_x,
    input  logic signed [COORD_WIDTH-1:0]       i_lv_y,
    input  logic signed [COORD_WIDTH-1:0]       i_lv_z,
    input  logic [2*COORD_WIDTH-3:0]            i_reach2,
    output logic                                o_valid,
    output logic [2*COORD_WIDTH-3:0]            o_rad,
    output lsva_pkg::t_side                     o_side
);
    import lsva_pkg::*;

    localparam int W    = COORD_WIDTH;
    localparam int DW   = W + 1;
    localparam int SQW  = 2 * W;
    localparam int D2W  = 2 * W + 2;
    localparam int PW   = DW + NORM_W;
    localparam int DOTW = PW + 2;
    localparam int RW   = 2 * W - 2;
    localparam int CW   = (D2W > 2 * FRAC_BITS + 13) ? D2W : 2 * FRAC_BITS + 13;
    localparam logic [CW-1:0] DCAM = CW'(2304) << (2 * FRAC_BITS);
    localparam logic [CW-1:0] DOBJ = CW'(81) << (2 * FRAC_BITS - 2);
    localparam int SH1  = 2 * FRAC_BITS - 8;
    localparam int SH2L = (18 - 2 * FRAC_BITS > 0) ? 18 - 2 * FRAC_BITS : 0;
    localparam int SH2R = (2 * FRAC_BITS - 18 > 0) ? 2 * FRAC_BITS - 18 : 0;

    logic signed [W-1:0]      s_p [3];
    logic signed [W-1:0]      s_c [3];
    logic signed [W-1:0]      s_o [3];
    logic signed [W-1:0]      s_l [3];
    logic signed [NORM_W-1:0] s_n [3];

    always_comb begin
        s_p[0] = i_vert_x; s_p[1] = i_vert_y; s_p[2] = i_vert_z;
        s_c[0] = i_cam_x;  s_c[1] = i_cam_y;  s_c[2] = i_cam_z;
        s_o[0] = i_obj_x;  s_o[1] = i_obj_y;  s_o[2] = i_obj_z;
        s_l[0] = i_lv_x;   s_l[1] = i_lv_y;   s_l[2] = i_lv_z;
        s_n[0] = i_norm_x; s_n[1] = i_norm_y; s_n[2] = i_norm_z;
    end

    // stage 1: differences
    logic                     r1_valid;
    logic signed [DW-1:0]     r1_lp [3];
    logic signed [DW-1:0]     r1_cp [3];
    logic signed [DW-1:0]     r1_op [3];
    logic signed [DW-1:0]     r1_v  [3];
    logic signed [NORM_W-1:0] r1_n  [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r1_lp[i] <= DW'(s_l[i]) - DW'(s_p[i]);
            r1_cp[i] <= DW'(s_c[i]) - DW'(s_p[i]);
            r1_op[i] <= DW'(s_o[i]) - DW'(s_p[i]);
            r1_v[i]  <= i_dir ? -DW'(s_l[i]) : DW'(s_l[i]) - DW'(s_p[i]);
            r1_n[i]  <= s_n[i];
        end
    end

    // stage 2: squares and dot terms
    logic signed [2*DW-1:0] s_sql [3];
    logic signed [2*DW-1:0] s_sqc [3];
    logic signed [2*DW-1:0] s_sqo [3];
    logic signed [PW-1:0]   s_prd [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s_sql[i] = r1_lp[i] * r1_lp[i];
            s_sqc[i] = r1_cp[i] * r1_cp[i];
            s_sqo[i] = r1_op[i] * r1_op[i];
            s_prd[i] = r1_v[i] * r1_n[i];
        end
    end

    logic                 r2_valid;
    logic [SQW-1:0]       r2_sl [3];
    logic [SQW-1:0]       r2_sc [3];
    logic [SQW-1:0]       r2_so [3];
    logic signed [PW-1:0] r2_p  [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r2_sl[i] <= s_sql[i][SQW-1:0];
            r2_sc[i] <= s_sqc[i][SQW-1:0];
            r2_so[i] <= s_sqo[i][SQW-1:0];
            r2_p[i]  <= s_prd[i];
        end
    end

    // stage 3: sums
    logic                   r3_valid;
    logic [D2W-1:0]         r3_d2l;
    logic [D2W-1:0]         r3_d2c;
    logic [D2W-1:0]         r3_d2o;
    logic signed [DOTW-1:0] r3_dot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_d2l <= {2'b00, r2_sl[0]} + {2'b00, r2_sl[1]} + {2'b00, r2_sl[2]};
        r3_d2c <= {2'b00, r2_sc[0]} + {2'b00, r2_sc[1]} + {2'b00, r2_sc[2]};
        r3_d2o <= {2'b00, r2_so[0]} + {2'b00, r2_so[1]} + {2'b00, r2_so[2]};
        r3_dot <= DOTW'(r2_p[0]) + DOTW'(r2_p[1]) + DOTW'(r2_p[2]);
    end

    // stage 4: compares and fade numerators
    logic          r4_valid;
    logic          r4_inreach;
    logic          r4_face;
    logic          r4_c_ok;
    logic          r4_o_ok;
    logic [CW-1:0] r4_x1;
    logic [CW-1:0] r4_x2;
    logic [RW-1:0] r4_d2l;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_inreach <= r3_d2l <= D2W'(i_reach2);
        r4_face    <= !r3_dot[DOTW-1] && (r3_dot != '0);
        r4_c_ok    <= CW'(r3_d2c) < DCAM;
        r4_o_ok    <= CW'(r3_d2o) < DOBJ;
        r4_x1      <= DCAM - CW'(r3_d2c);
        r4_x2      <= DOBJ - CW'(r3_d2o);
        r4_d2l     <= r3_d2l[RW-1:0];
    end

    // stage 5: reciprocal multiplies
    logic [19:0] s_xs1;
    logic [22:0] s_xs2;
    logic        s_use_div;

    assign s_xs1     = 20'(r4_x1 >> SH1);
    assign s_xs2     = 23'((r4_x2 << SH2L) >> SH2R);
    assign s_use_div = !i_dir && r4_inreach && r4_face;

    logic          r5_valid;
    logic [40:0]   r5_p1;
    logic [46:0]   r5_p2;
    logic          r5_c_ok;
    logic          r5_o_ok;
    logic          r5_full;
    logic          r5_use_div;
    logic [RW-1:0] r5_rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else begin
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_p1      <= 41'(s_xs1) * 41'(RECIP_9);
        r5_p2      <= 47'(s_xs2) * 47'(RECIP_81);
        r5_c_ok    <= r4_c_ok;
        r5_o_ok    <= r4_o_ok;
        r5_full    <= i_dir && r4_face;
        r5_use_div <= s_use_div;
        r5_rad     <= s_use_div ? r4_d2l : '0;
    end

    always_comb begin
        o_side.f1      = r5_c_ok ? r5_p1[RECIP_9_SH +: FADE_W] : '0;
        o_side.f2      = r5_o_ok ? r5_p2[RECIP_81_SH +: FADE_W] : '0;
        o_side.full    = r5_full;
        o_side.use_div = r5_use_div;
    end

    assign o_valid = r5_valid;
    assign o_rad   = r5_rad;

endmodule

// ----- sv/lsva_sqrt.sv -----
// Pipelined integer square root, one root bit per stage.
// Depends on lsva_pkg.
module lsva_sqrt #(
    parameter int RT = 19
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [2*RT-1:0]   i_rad,
    input  lsva_pkg::t_side   i_side,
    output logic              o_valid,
    output logic [RT-1:0]     o_root,
    output lsva_pkg::t_side   o_side
);
    import lsva_pkg::*;

    logic            r_vld  [RT];
    logic [RT+1:0]   r_rem  [RT];
    logic [RT-1:0]   r_root [RT];
    logic [2*RT-1:0] r_rad  [RT];
    t_side           r_side [RT];

    for (genvar i = 0; i < RT; i++) begin : g_st
        logic            s_vld;
        logic [RT+1:0]   s_rem;
        logic [RT-1:0]   s_root;
        logic [2*RT-1:0] s_rad;
        t_side           s_side;
        logic [RT+1:0]   s_sh;
        logic [RT+1:0]   s_trial;

        if (i == 0) begin : g_first
            assign s_vld  = i_valid;
            assign s_rem  = '0;
            assign s_root = '0;
            assign s_rad  = i_rad;
            assign s_side = i_side;
        end else begin : g_next
            assign s_vld  = r_vld[i-1];
            assign s_rem  = r_rem[i-1];
            assign s_root = r_root[i-1];
            assign s_rad  = r_rad[i-1];
            assign s_side = r_side[i-1];
        end

        assign s_sh    = {s_rem[RT-1:0], s_rad[2*RT-1 -: 2]};
        assign s_trial = {s_root, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else begin
                r_vld[i] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (s_sh >= s_trial) begin
                r_rem[i]  <= s_sh - s_trial;
                r_root[i] <= {s_root[RT-2:0], 1'b1};
            end else begin
                r_rem[i]  <= s_sh;
                r_root[i] <= {s_root[RT-2:0], 1'b0};
            end
            r_rad[i]  <= s_rad << 2;
            r_side[i] <= s_side;
        end
    end

    assign o_valid = r_vld[RT-1];
    assign o_root  = r_root[RT-1];
    assign o_side  = r_side[RT-1];

endmodule

// ----- sv/lsva_div.sv -----
// Pipelined restoring divider for r*2^16/(r + 2^FRAC_BITS), one bit per stage.
// Depends on lsva_pkg.
module lsva_div #(
    parameter int RT        = 19,
    parameter int FRAC_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [RT-1:0]                 i_root,
    input  lsva_pkg::t_side               i_side,
    output logic                          o_valid,
    output logic [lsva_pkg::QUOT_W-1:0]   o_quot,
    output lsva_pkg::t_side               o_side
);
    import lsva_pkg::*;

    localparam logic [RT:0] ONE_R = (RT + 1)'(1) << FRAC_BITS;

    logic              r_vld [QUOT_W];
    logic [RT:0]       r_rem [QUOT_W];
    logic [RT:0]       r_den [QUOT_W];
    logic [QUOT_W-1:0] r_q   [QUOT_W];
    t_side             r_side [QUOT_W];

    for (genvar i = 0; i < QUOT_W; i++) begin : g_st
        logic              s_vld;
        logic [RT:0]       s_rem;
        logic [RT:0]       s_den;
        logic [QUOT_W-1:0] s_q;
        t_side             s_side;
        logic [RT+1:0]     s_sh;

        if (i == 0) begin : g_first
            assign s_vld  = i_valid;
            assign s_rem  = {1'b0, i_root};
            assign s_den  = {1'b0, i_root} + ONE_R;
            assign s_q    = '0;
            assign s_side = i_side;
        end else begin : g_next
            assign s_vld  = r_vld[i-1];
            assign s_rem  = r_rem[i-1];
            assign s_den  = r_den[i-1];
            assign s_q    = r_q[i-1];
            assign s_side = r_side[i-1];
        end

        assign s_sh = {s_rem, 1'b0};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else begin
                r_vld[i] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (s_sh >= {1'b0, s_den}) begin
                r_rem[i] <= s_sh[RT:0] - s_den;
                r_q[i]   <= {s_q[QUOT_W-2:0], 1'b1};
            end else begin
                r_rem[i] <= s_sh[RT:0];
                r_q[i]   <= {s_q[QUOT_W-2:0], 1'b0};
            end
            r_den[i]  <= s_den;
            r_side[i] <= s_side;
        end
    end

    assign o_valid = r_vld[QUOT_W-1];
    assign o_quot  = r_q[QUOT_W-1];
    assign o_side  = r_side[QUOT_W-1];

endmodule

// ----- sv/lsva_mix.sv -----
// Back end: energy, attenuation and fade products, alpha and saturation.
// Depends on lsva_pkg.
module lsva_mix (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic [lsva_pkg::QUOT_W-1:0]          i_quot,
    input  lsva_pkg::t_side                      i_side,
    input  logic [lsva_pkg::ENERGY_W-1:0]        i_energy,
    output logic                                 o_done,
    output logic signed [lsva_pkg::ALPHA_W-1:0]  o_alpha
);
    import lsva_pkg::*;

    logic [ATT_W-1:0] s_att;

    always_comb begin
        priority if (i_side.full) begin
            s_att = ATT_FULL;
        end else if (i_side.use_div) begin
            s_att = {1'b0, i_quot};
        end else begin
            s_att = '0;
        end
    end

    logic              r1_vld;
    logic [25:0]       r1_ea;
    logic [FADE_W-1:0] r1_f1;
    logic [FADE_W-1:0] r1_f2;
    logic              r2_vld;
    logic [42:0]       r2_eaf;
    logic [FADE_W-1:0] r2_f2;
    logic              r3_vld;
    logic [43:0]       r3_mm;
    logic              r4_vld;
    logic [37:0]       r4_k;
    logic              r_done;
    logic signed [ALPHA_W-1:0] r_alpha;

    logic signed [13:0] s_a;
    assign s_a = 14'sd255 - $signed({1'b0, r4_k[37:25]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r_done <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_ea  <= 26'(i_energy) * 26'(s_att);
        r1_f1  <= i_side.f1;
        r1_f2  <= i_side.f2;
        r2_eaf <= 43'(r1_ea) * 43'(r1_f1);
        r2_f2  <= r1_f2;
        r3_mm  <= 44'(r2_eaf[42:16]) * 44'(r2_f2);
        r4_k   <= 38'(r3_mm[43:16]) * 38'(ALPHA_SCALE);
        if (s_a < -14'sd127) begin
            r_alpha <= -9'sd127;
        end else begin
            r_alpha <= s_a[ALPHA_W-1:0];
        end
    end

    assign o_done  = r_done;
    assign o_alpha = r_alpha;

    a_side_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> !(i_side.full && i_side.use_div))
        else $error("attenuation select not exclusive");

    a_alpha_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_alpha >= -9'sd127)
        else $error("alpha below saturation floor");

    a_unlit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_side.full && !i_side.use_div) |-> ##5 (o_done && o_alpha == 9'sd255))
        else $error("unlit vertex not fully opaque");

endmodule

// ----- sv/light_shadow_vertex_alpha_top.sv -----
// Shadow vertex alpha: one vertex per clock; each result passes front end 5,
// square root COORD_WIDTH-1 stages, divider 16 stages, back end 5 in turn.
// Fully pipelined, o_busy stays low, no stall.
// Synchronous active-low reset clears the pipeline valid bits and light registers.
// Depends on lsva_pkg, lsva_geom, lsva_sqrt, lsva_div, lsva_mix.
module light_shadow_vertex_alpha_top #(
    parameter int COORD_WIDTH = 20,
    parameter int FRAC_BITS   = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    output logic                                  o_busy,
    input  logic signed [COORD_WIDTH-1:0]         i_vert_x,
    input  logic signed [COORD_WIDTH-1:0]         i_vert_y,
    input  logic signed [COORD_WIDTH-1:0]         i_vert_z,
    input  logic signed [lsva_pkg::NORM_W-1:0]    i_norm_x,
    input  logic signed [lsva_pkg::NORM_W-1:0]    i_norm_y,
    input  logic signed [lsva_pkg::NORM_W-1:0]    i_norm_z,
    input  logic signed [COORD_WIDTH-1:0]         i_cam_x,
    input  logic signed [COORD_WIDTH-1:0]         i_cam_y,
    input  logic signed [COORD_WIDTH-1:0]         i_cam_z,
    input  logic signed [COORD_WIDTH-1:0]         i_obj_x,
    input  logic signed [COORD_WIDTH-1:0]         i_obj_y,
    input  logic signed [COORD_WIDTH-1:0]         i_obj_z,
    output logic                                  o_done,
    output logic signed [lsva_pkg::ALPHA_W-1:0]   o_shadow_alpha,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [lsva_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [COORD_WIDTH-1:0]                i_cfg_data
);
    import lsva_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int RT = W - 1;

    logic                   r_dir;
    logic signed [W-1:0]    r_lv_x;
    logic signed [W-1:0]    r_lv_y;
    logic signed [W-1:0]    r_lv_z;
    logic [RT-1:0]          r_reach;
    logic [ENERGY_W-1:0]    r_energy;
    logic [2*RT-1:0]        r_reach2;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir    <= 1'b0;
            r_lv_x   <= '0;
            r_lv_y   <= '0;
            r_lv_z   <= '0;
            r_reach  <= '0;
            r_energy <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_DIR:    r_dir    <= i_cfg_data[0];
                CFG_VEC_X:  r_lv_x   <= i_cfg_data;
                CFG_VEC_Y:  r_lv_y   <= i_cfg_data;
                CFG_VEC_Z:  r_lv_z   <= i_cfg_data;
                CFG_REACH:  r_reach  <= i_cfg_data[RT-1:0];
                CFG_ENERGY: r_energy <= i_cfg_data[ENERGY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_reach2 <= r_reach * r_reach;
    end

    logic            s_accept;
    logic            g_valid;
    logic [2*RT-1:0] g_rad;
    t_side           g_side;
    logic            q_valid;
    logic [RT-1:0]   q_root;
    t_side           q_side;
    logic            d_valid;
    logic [QUOT_W-1:0] d_quot;
    t_side           d_side;

    assign s_accept = i_start && !o_busy;

    lsva_geom #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_geom (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_accept),
        .i_vert_x (i_vert_x),
        .i_vert_y (i_vert_y),
        .i_vert_z (i_vert_z),
        .i_norm_x (i_norm_x),
        .i_norm_y (i_norm_y),
        .i_norm_z (i_norm_z),
        .i_cam_x  (i_cam_x),
        .i_cam_y  (i_cam_y),
        .i_cam_z  (i_cam_z),
        .i_obj_x  (i_obj_x),
        .i_obj_y  (i_obj_y),
        .i_obj_z  (i_obj_z),
        .i_dir    (r_dir),
        .i_lv_x   (r_lv_x),
        .i_lv_y   (r_lv_y),
        .i_lv_z   (r_lv_z),
        .i_reach2 (r_reach2),
        .o_valid  (g_valid),
        .o_rad    (g_rad),
        .o_side   (g_side)
    );

    lsva_sqrt #(
        .RT (RT)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (g_valid),
        .i_rad   (g_rad),
        .i_side  (g_side),
        .o_valid (q_valid),
        .o_root  (q_root),
        .o_side  (q_side)
    );

    lsva_div #(
        .RT        (RT),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_root  (q_root),
        .i_side  (q_side),
        .o_valid (d_valid),
        .o_quot  (d_quot),
        .o_side  (d_side)
    );

    lsva_mix u_mix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (d_valid),
        .i_quot   (d_quot),
        .i_side   (d_side),
        .i_energy (r_energy),
        .o_done   (o_done),
        .o_alpha  (o_shadow_alpha)
    );

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for light_shadow_vertex_alpha_top: drives vertex beats and
// light register writes, predicts each shadow alpha in fixed point and checks results.
// Depends on lsva_pkg and the light_shadow_vertex_alpha_top RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lsva_pkg::*;

    localparam int  CW         = 20;
    localparam int  FB         = 8;
    localparam int  WDOG_LIMIT = 4000;
    localparam int  DRAIN_GAP  = 60;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam longint CMAX = 524287;
    localparam longint CMIN = -524288;

    typedef struct {
        longint pos[3];
        longint nrm[3];
        longint cam[3];
        longint obj[3];
    } vertex_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic               o_busy;
    logic signed [CW-1:0] i_vert_x = '0, i_vert_y = '0, i_vert_z = '0;
    logic signed [NORM_W-1:0] i_norm_x = '0, i_norm_y = '0, i_norm_z = '0;
    logic signed [CW-1:0] i_cam_x = '0, i_cam_y = '0, i_cam_z = '0;
    logic signed [CW-1:0] i_obj_x = '0, i_obj_y = '0, i_obj_z = '0;
    logic               o_done;
    logic signed [ALPHA_W-1:0] o_shadow_alpha;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CW-1:0]      i_cfg_data = '0;

    // light registers as the block should hold them
    logic               lt_directional;
    longint             lt_vec[3];
    longint             lt_reach;
    longint             lt_energy;

    logic [ALPHA_W-1:0] alpha_due[$];
    int                 errors;
    int                 quiet_cycles;
    bit                 accepted_now;
    bit                 idle_on;

    always #2 i_clk = ~i_clk;

    light_shadow_vertex_alpha_top #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) u_top (.*);

    function automatic longint sq_dist(const ref longint a[3], const ref longint b[3]);
        longint s;
        s = 0;
        for (int k = 0; k < 3; k++) s += (a[k] - b[k]) * (a[k] - b[k]);
        return s;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint lo, hi, mid;
        lo = 0;
        hi = 2097152;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= v) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic longint fade_q16(longint d2, longint lim);
        if (d2 >= lim) return 0;
        return ((lim - d2) << 16) / lim;
    endfunction

    function automatic logic [ALPHA_W-1:0] predict_alpha(vertex_t v);
        longint att, dot, d2, r, f1, f2, m, alpha;
        att = 0;
        if (lt_directional) begin
            dot = -(lt_vec[0] * v.nrm[0] + lt_vec[1] * v.nrm[1] + lt_vec[2] * v.nrm[2]);
            if (dot > 0) att = 65536;
        end else begin
            d2 = sq_dist(v.pos, lt_vec);
            if (d2 <= lt_reach * lt_reach) begin
                dot = (lt_vec[0] - v.pos[0]) * v.nrm[0] + (lt_vec[1] - v.pos[1]) * v.nrm[1]
                    + (lt_vec[2] - v.pos[2]) * v.nrm[2];
                if (dot > 0) begin
                    r = int_sqrt(d2);
                    att = (r << 16) / (r + (1 << FB));
                end
            end
        end
        f1 = fade_q16(sq_dist(v.cam, v.pos), 64'd2304 << (2 * FB));
        f2 = fade_q16(sq_dist(v.obj, v.pos), 64'd81 << (2 * FB - 2));
        m = (lt_energy * att * f1) >> 16;
        m = (m * f2) >> 16;
        alpha = 255 - ((765 * m) >> 25);
        if (alpha < -127) alpha = -127;
        if (alpha > 255) alpha = 255;
        return alpha[ALPHA_W-1:0];
    endfunction

    function automatic longint rnd_between(longint lo, longint hi);
        return lo + longint'($urandom_range(0, int'(hi - lo)));
    endfunction

    function automatic longint clamp_coord(longint c);
        return (c > CMAX) ? CMAX : (c < CMIN) ? CMIN : c;
    endfunction

    function automatic vertex_t random_vertex(int sel);
        vertex_t v;
        for (int k = 0; k < 3; k++) begin
            v.nrm[k] = rnd_between(-16384, 16384);
            if (sel < 15) begin
                v.pos[k] = rnd_between(CMIN, CMAX);
                v.cam[k] = rnd_between(CMIN, CMAX);
                v.obj[k] = rnd_between(CMIN, CMAX);
            end else begin
                if (sel < 55) v.pos[k] = clamp_coord(lt_vec[k] + rnd_between(-3000, 3000));
                else v.pos[k] = rnd_between(-400000, 400000);
                v.cam[k] = clamp_coord(v.pos[k] + rnd_between(-8000, 8000));
                v.obj[k] = clamp_coord(v.pos[k] + rnd_between(-700, 700));
            end
        end
        return v;
    endfunction

    task automatic report_mismatch(string what, logic [ALPHA_W-1:0] got,
                                   logic [ALPHA_W-1:0] want);
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what,
                 $signed(got), $signed(want));
        errors++;
    endtask

    task automatic send_vertex(vertex_t v);
        @(negedge i_clk);
        i_vert_x <= v.pos[0][CW-1:0];
        i_vert_y <= v.pos[1][CW-1:0];
        i_vert_z <= v.pos[2][CW-1:0];
        i_norm_x <= v.nrm[0][NORM_W-1:0];
        i_norm_y <= v.nrm[1][NORM_W-1:0];
        i_norm_z <= v.nrm[2][NORM_W-1:0];
        i_cam_x  <= v.cam[0][CW-1:0];
        i_cam_y  <= v.cam[1][CW-1:0];
        i_cam_z  <= v.cam[2][CW-1:0];
        i_obj_x  <= v.obj[0][CW-1:0];
        i_obj_y  <= v.obj[1][CW-1:0];
        i_obj_z  <= v.obj[2][CW-1:0];
        i_start  <= 1'b1;
        do @(posedge i_clk); while (o_busy);
        alpha_due.push_back(predict_alpha(v));
        accepted_now = 1'b1;
        if (idle_on && $urandom_range(0, 9) == 0) begin
            @(negedge i_clk);
            i_start <= 1'b0;
            repeat ($urandom_range(1, 18) - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (alpha_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    task automatic write_light(logic [CFG_IDX_W-1:0] idx, longint value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CW-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        accepted_now = 1'b1;
        case (idx)
            CFG_DIR:    lt_directional = value[0];
            CFG_VEC_X:  lt_vec[0] = longint'(signed'(value[CW-1:0]));
            CFG_VEC_Y:  lt_vec[1] = longint'(signed'(value[CW-1:0]));
            CFG_VEC_Z:  lt_vec[2] = longint'(signed'(value[CW-1:0]));
            CFG_REACH:  lt_reach = longint'(value[CW-2:0]);
            CFG_ENERGY: lt_energy = longint'(value[ENERGY_W-1:0]);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_light(bit dirl, longint x, longint y, longint z, longint reach,
                             longint energy);
        write_light(CFG_DIR, dirl);
        write_light(CFG_VEC_X, x);
        write_light(CFG_VEC_Y, y);
        write_light(CFG_VEC_Z, z);
        write_light(CFG_REACH, reach);
        write_light(CFG_ENERGY, energy);
    endtask

    task automatic run_random(int count);
        for (int n = 0; n < count; n++) send_vertex(random_vertex($urandom_range(0, 99)));
    endtask

    task automatic test_reset_state();
        vertex_t v;
        v = random_vertex(50);
        send_vertex(v);
        drain_results();
    endtask

    task automatic test_directed();
        vertex_t v;
        set_light(1'b0, 1000, -2000, 500, CMAX, 256);
        for (int k = 0; k < 3; k++) begin
            v.pos[k] = 0; v.cam[k] = 0; v.obj[k] = 0; v.nrm[k] = 0;
        end
        send_vertex(v);                         // zero normal
        v.nrm[0] = 16384;
        send_vertex(v);                         // facing, vertex at cam and object
        v.nrm[0] = -16384;
        send_vertex(v);                         // facing away
        v.nrm[0] = 16384; v.nrm[1] = -16384; v.nrm[2] = 16384;
        v.pos[0] = lt_vec[0] - 1; v.pos[1] = lt_vec[1]; v.pos[2] = lt_vec[2];
        v.cam = v.pos; v.obj = v.pos;
        send_vertex(v);                         // one raw unit from the light
        v.pos = lt_vec; v.cam = v.pos; v.obj = v.pos;
        send_vertex(v);                         // vertex on the light
        for (int k = 0; k < 3; k++) begin
            v.pos[k] = CMAX; v.cam[k] = CMIN; v.obj[k] = CMIN;
        end
        send_vertex(v);                         // extremes, beyond reach
        for (int k = 0; k < 3; k++) begin
            v.pos[k] = CMIN; v.cam[k] = CMAX; v.obj[k] = CMAX; v.nrm[k] = -16384;
        end
        send_vertex(v);
        v.pos[0] = 0; v.pos[1] = 0; v.pos[2] = 0;
        v.cam[0] = 12288; v.cam[1] = 0; v.cam[2] = 0;
        v.obj[0] = 0; v.obj[1] = 1152; v.obj[2] = 0;
        v.nrm[0] = 16384; v.nrm[1] = 0; v.nrm[2] = 0;
        send_vertex(v);                         // camera and object exactly at fade limit
        v.cam[0] = 12287; v.obj[1] = 1151;
        send_vertex(v);
        drain_results();
        set_light(1'b0, 0, 0, 0, 0, 256);       // zero reach: only the light spot itself
        v.pos[0] = 0; v.pos[1] = 0; v.pos[2] = 0; v.cam = v.pos; v.obj = v.pos;
        send_vertex(v);
        v.pos[0] = 1; v.cam = v.pos; v.obj = v.pos;
        send_vertex(v);
        drain_results();
        set_light(1'b0, 5000, 0, 0, 2000, 256); // reach boundary
        v.pos[0] = 3000; v.pos[1] = 0; v.pos[2] = 0; v.cam = v.pos; v.obj = v.pos;
        send_vertex(v);
        v.pos[0] = 2999; v.cam = v.pos; v.obj = v.pos;
        send_vertex(v);
        drain_results();
        set_light(1'b1, CMIN, CMAX, 0, 0, 511); // directional, energy above unity
        v.nrm[0] = 16384; v.nrm[1] = 0; v.nrm[2] = 0;
        send_vertex(v);
        v.nrm[0] = 0; v.nrm[1] = 16384;
        send_vertex(v);
        v.nrm[1] = 0;
        send_vertex(v);
        drain_results();
    endtask

    task automatic test_spare_index();
        set_light(1'b0, 0, 0, 0, 100000, 200);
        write_light(CFG_SPARE_LO, CMAX);
        write_light(CFG_SPARE_HI, 20'hFFFFF);
        run_random(20);
        drain_results();
    endtask

    task automatic test_point_light();
        set_light(1'b0, rnd_between(CMIN, CMAX), rnd_between(CMIN, CMAX),
                  rnd_between(CMIN, CMAX), CMAX, 256);
        run_random(400);
        drain_results();
        set_light(1'b0, rnd_between(-2000, 2000), rnd_between(-2000, 2000),
                  rnd_between(-2000, 2000), 2500, 173);
        run_random(350);
        drain_results();
    endtask

    task automatic test_directional_light();
        set_light(1'b1, rnd_between(CMIN, CMAX), rnd_between(CMIN, CMAX),
                  rnd_between(CMIN, CMAX), 0, 256);
        run_random(350);
        drain_results();
    endtask

    task automatic test_energy_extremes();
        set_light(1'b0, 0, 0, 0, CMAX, 0);
        run_random(100);
        drain_results();
        set_light(1'b1, 300, -300, 0, 0, 511);
        run_random(200);
        drain_results();
    endtask

    task automatic test_full_rate();
        idle_on = 1'b0;
        set_light(1'b0, 1000, 1000, 1000, 20000, 384);
        run_random(200);
        drain_results();
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            accepted_now = 1'b1;
            if (alpha_due.size() == 0) begin
                $display("ERROR %0t: result beat with nothing outstanding", $realtime);
                errors++;
            end else if (o_shadow_alpha !== alpha_due[0]) begin
                report_mismatch("shadow_alpha", o_shadow_alpha, alpha_due.pop_front());
            end else begin
                void'(alpha_due.pop_front());
            end
        end
    end

    always @(negedge i_clk) begin
        if (accepted_now || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        accepted_now = 1'b0;
        if (quiet_cycles >= WDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        errors = 0;
        quiet_cycles = 0;
        accepted_now = 1'b0;
        idle_on = 1'b1;
        lt_directional = 1'b0;
        lt_vec = '{0, 0, 0};
        lt_reach = 0;
        lt_energy = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_directed();
        test_spare_index();
        test_point_light();
        test_directional_light();
        test_energy_extremes();
        test_full_rate();
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// ----- light_shadow_vertex_alpha_top.f -----
sv/lsva_pkg.sv
sv/lsva_geom.sv
sv/lsva_sqrt.sv
sv/lsva_div.sv
sv/lsva_mix.sv
sv/light_shadow_vertex_alpha_top.sv
tb/tb.sv
